// ----- design/sensor_baseline_ema_level_meter_assert.svh -----
// Assertion macros used by the level meter top level.
`ifndef SENSOR_BASELINE_EMA_LEVEL_METER_ASSERT_SVH
`define SENSOR_BASELINE_EMA_LEVEL_METER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBELM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBELM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sbelm_pkg.sv -----
// Shared constants and controller/datapath interface types for the level meter.
`timescale 1ns / 1ps
package sbelm_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int SAMPLES_PER_AVG = 16;
  localparam int GROUP_BITS      = $clog2(SAMPLES_PER_AVG);
  localparam int GSUM_BITS       = SAMPLE_BITS + GROUP_BITS;
  localparam int FRAC_BITS       = 8;
  localparam int LEVEL_BITS      = SAMPLE_BITS + FRAC_BITS;
  localparam int CALIB_BITS      = 10;
  localparam int CSUM_BITS       = SAMPLE_BITS + CALIB_BITS;
  localparam int HALF_BITS       = 11;
  localparam int STRIP_BITS      = 8;
  localparam int GAIN_BITS       = 9;
  localparam int DELTA_BITS      = 13;
  localparam int DIFF_BITS       = LEVEL_BITS + 1;
  localparam int PROD_BITS       = DIFF_BITS + GAIN_BITS + 1;
  localparam int STEP_BITS       = PROD_BITS - FRAC_BITS;
  localparam int FSUM_BITS       = LEVEL_BITS + 4;
  localparam int SPAN_BITS       = HALF_BITS + 1;
  localparam int NUM_BITS        = SPAN_BITS + STRIP_BITS;
  localparam int DIV_BITS        = CSUM_BITS + FRAC_BITS;
  localparam int DVS_BITS        = SPAN_BITS;
  localparam int DIV_CNT_BITS    = $clog2(DIV_BITS);
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 12;

  localparam logic [GROUP_BITS-1:0] GROUP_LAST = GROUP_BITS'(SAMPLES_PER_AVG - 1);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = {LEVEL_BITS{1'b1}};

  localparam logic [HALF_BITS-1:0]   HALF_RANGE_RST   = HALF_BITS'(100);
  localparam logic [STRIP_BITS-1:0]  STRIP_LENGTH_RST = STRIP_BITS'(40);
  localparam logic [CALIB_BITS-1:0]  CALIB_COUNT_RST  = CALIB_BITS'(256);
  localparam logic [GAIN_BITS-1:0]   FILTER_GAIN_RST  = GAIN_BITS'(51);
  localparam logic [SAMPLE_BITS-1:0] RAIL_HIGH_RST    = SAMPLE_BITS'(4090);
  localparam logic [SAMPLE_BITS-1:0] RAIL_LOW_RST     = SAMPLE_BITS'(5);

  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_RANGE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRIP_LENGTH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CALIB_COUNT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_GAIN  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAIL_HIGH    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAIL_LOW     = 3'd5;

  typedef struct packed {
    logic acc;
    logic cal_add;
    logic div_start;
    logic div_sel_map;
    logic base_load;
    logic mul;
    logic upd;
    logic dlt;
    logic out_load;
  } sbelm_cmd_t;

  typedef struct packed {
    logic group_last;
    logic calibrated;
    logic cal_last;
    logic div_busy;
    logic div_done;
  } sbelm_sts_t;

endpackage

// ----- design/sbelm_div.sv -----
// Restoring radix-2 divider shared by the baseline and bar mapping steps.
`timescale 1ns / 1ps
module sbelm_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [sbelm_pkg::DIV_BITS-1:0]      dividend_i,
  input  logic [sbelm_pkg::DVS_BITS-1:0]      divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [sbelm_pkg::DIV_BITS-1:0]      quotient_o
);
  import sbelm_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_BITS-1:0]     quo_q, quo_d;
  logic [DVS_BITS-1:0]     rem_q, rem_d;
  logic [DVS_BITS-1:0]     dvs_q, dvs_d;
  logic [DVS_BITS:0]       trial;
  logic                    fits;

  assign trial = {rem_q, quo_q[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_BITS'(DIV_BITS - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_BITS-2:0], fits};
      rem_d = fits ? DVS_BITS'(trial - {1'b0, dvs_q}) : trial[DVS_BITS-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/sbelm_dp.sv -----
// Datapath: configuration registers, averaging, calibration, filter and bar mapping.
`timescale 1ns / 1ps
module sbelm_dp (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [sbelm_pkg::CFG_IDX_BITS-1:0]         cfg_index_i,
  input  logic [sbelm_pkg::CFG_DATA_BITS-1:0]        cfg_data_i,
  input  logic [sbelm_pkg::SAMPLE_BITS-1:0]          sample_i,
  input  sbelm_pkg::sbelm_cmd_t                      cmd_i,
  output sbelm_pkg::sbelm_sts_t                      sts_o,
  output logic [sbelm_pkg::STRIP_BITS-1:0]           lit_count_o,
  output logic                                       rail_hit_o,
  output logic signed [sbelm_pkg::DELTA_BITS-1:0]    level_delta_o,
  output logic [sbelm_pkg::SAMPLE_BITS-1:0]          average_level_o
);
  import sbelm_pkg::*;

  logic [HALF_BITS-1:0]   half_range_q;
  logic [STRIP_BITS-1:0]  strip_length_q;
  logic [CALIB_BITS-1:0]  calib_count_q;
  logic [GAIN_BITS-1:0]   filter_gain_q;
  logic [SAMPLE_BITS-1:0] rail_high_q;
  logic [SAMPLE_BITS-1:0] rail_low_q;

  logic [GSUM_BITS-1:0]   group_sum_q;
  logic [GROUP_BITS-1:0]  group_idx_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [CSUM_BITS-1:0]   calib_sum_q;
  logic [CALIB_BITS-1:0]  calib_idx_q;
  logic                   calibrated_q;
  logic [LEVEL_BITS-1:0]  base_q;
  logic [LEVEL_BITS-1:0]  filt_q;
  logic signed [PROD_BITS-1:0]  prod_q;
  logic signed [DELTA_BITS-1:0] delta_q;
  logic                   rail_q;

  logic [STRIP_BITS-1:0]        lit_out_q;
  logic                         rail_out_q;
  logic signed [DELTA_BITS-1:0] delta_out_q;
  logic [SAMPLE_BITS-1:0]       avg_out_q;

  logic [GSUM_BITS-1:0]         gsum_next;
  logic [CALIB_BITS:0]          calib_next;
  logic signed [DIFF_BITS-1:0]  diff;
  logic signed [PROD_BITS-1:0]  prod_d;
  logic signed [STEP_BITS-1:0]  step;
  logic signed [FSUM_BITS-1:0]  fsum;
  logic [LEVEL_BITS-1:0]        filt_upd;
  logic signed [DIFF_BITS-1:0]  dev;
  logic signed [DIFF_BITS-1:0]  dev_adj;
  logic [HALF_BITS-1:0]         h;
  logic signed [DELTA_BITS-1:0] hs;
  logic signed [DELTA_BITS-1:0] clamped;
  logic signed [DELTA_BITS-1:0] span_s;
  logic [NUM_BITS-1:0]          num;
  logic [DIV_BITS-1:0]          div_dividend;
  logic [DVS_BITS-1:0]          div_divisor;
  logic                         div_busy;
  logic                         div_done;
  logic [DIV_BITS-1:0]          div_quo;

  assign gsum_next  = group_sum_q + GSUM_BITS'(sample_i);
  assign calib_next = {1'b0, calib_idx_q} + 1'b1;

  assign diff   = $signed({1'b0, avg_q, {FRAC_BITS{1'b0}}}) - $signed({1'b0, filt_q});
  assign prod_d = $signed({1'b0, filter_gain_q}) * diff;
  assign step   = prod_q[PROD_BITS-1:FRAC_BITS];
  assign fsum   = $signed({{(FSUM_BITS-LEVEL_BITS){1'b0}}, filt_q})
                + {{(FSUM_BITS-STEP_BITS){step[STEP_BITS-1]}}, step};

  always_comb begin
    if (fsum < 0) begin
      filt_upd = '0;
    end else if (fsum > $signed({{(FSUM_BITS-LEVEL_BITS){1'b0}}, LEVEL_MAX})) begin
      filt_upd = LEVEL_MAX;
    end else begin
      filt_upd = fsum[LEVEL_BITS-1:0];
    end
  end

  assign dev     = $signed({1'b0, filt_q}) - $signed({1'b0, base_q});
  assign dev_adj = dev[DIFF_BITS-1] ? dev + DIFF_BITS'(255) : dev;

  assign h  = (half_range_q == '0) ? HALF_BITS'(1) : half_range_q;
  assign hs = $signed({{(DELTA_BITS-HALF_BITS){1'b0}}, h});

  always_comb begin
    if (delta_q > hs) begin
      clamped = hs;
    end else if (delta_q < -hs) begin
      clamped = -hs;
    end else begin
      clamped = delta_q;
    end
  end

  assign span_s = clamped + hs;
  assign num    = span_s[SPAN_BITS-1:0] * strip_length_q;

  assign div_dividend = cmd_i.div_sel_map ? DIV_BITS'(num)
                                          : {calib_sum_q, {FRAC_BITS{1'b0}}};
  assign div_divisor  = cmd_i.div_sel_map ? {h, 1'b0} : DVS_BITS'(calib_idx_q);

  sbelm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_range_q   <= HALF_RANGE_RST;
      strip_length_q <= STRIP_LENGTH_RST;
      calib_count_q  <= CALIB_COUNT_RST;
      filter_gain_q  <= FILTER_GAIN_RST;
      rail_high_q    <= RAIL_HIGH_RST;
      rail_low_q     <= RAIL_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HALF_RANGE:   half_range_q   <= cfg_data_i[HALF_BITS-1:0];
        CFG_STRIP_LENGTH: strip_length_q <= cfg_data_i[STRIP_BITS-1:0];
        CFG_CALIB_COUNT:  calib_count_q  <= cfg_data_i[CALIB_BITS-1:0];
        CFG_FILTER_GAIN:  filter_gain_q  <= cfg_data_i[GAIN_BITS-1:0];
        CFG_RAIL_HIGH:    rail_high_q    <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_RAIL_LOW:     rail_low_q     <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_sum_q  <= '0;
      group_idx_q  <= '0;
      calib_sum_q  <= '0;
      calib_idx_q  <= '0;
      calibrated_q <= 1'b0;
      base_q       <= '0;
      filt_q       <= '0;
    end else begin
      if (cmd_i.acc) begin
        if (group_idx_q == GROUP_LAST) begin
          group_sum_q <= '0;
          group_idx_q <= '0;
        end else begin
          group_sum_q <= gsum_next;
          group_idx_q <= group_idx_q + 1'b1;
        end
      end
      if (cmd_i.cal_add) begin
        calib_sum_q <= calib_sum_q + CSUM_BITS'(avg_q);
        calib_idx_q <= calib_next[CALIB_BITS-1:0];
      end
      if (cmd_i.base_load) begin
        base_q       <= div_quo[LEVEL_BITS-1:0];
        filt_q       <= div_quo[LEVEL_BITS-1:0];
        calibrated_q <= 1'b1;
      end else if (cmd_i.upd) begin
        filt_q <= filt_upd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && (group_idx_q == GROUP_LAST)) begin
      avg_q <= gsum_next[GSUM_BITS-1:GROUP_BITS];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.dlt) begin
      delta_q <= dev_adj[DIFF_BITS-1:FRAC_BITS];
      rail_q  <= (avg_q >= rail_high_q) || (avg_q <= rail_low_q);
    end
    if (cmd_i.out_load) begin
      lit_out_q   <= div_quo[STRIP_BITS-1:0];
      rail_out_q  <= rail_q;
      delta_out_q <= delta_q;
      avg_out_q   <= avg_q;
    end
  end

  assign sts_o.group_last = group_idx_q == GROUP_LAST;
  assign sts_o.calibrated = calibrated_q;
  assign sts_o.cal_last   = calib_next >= {1'b0, calib_count_q};
  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;

  assign lit_count_o     = lit_out_q;
  assign rail_hit_o      = rail_out_q;
  assign level_delta_o   = delta_out_q;
  assign average_level_o = avg_out_q;

endmodule

// ----- design/sbelm_ctrl.sv -----
// Controller state machine sequencing the level meter datapath.
`timescale 1ns / 1ps
module sbelm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  sbelm_pkg::sbelm_sts_t sts_i,
  output sbelm_pkg::sbelm_cmd_t cmd_o
);
  import sbelm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CAL    = 4'd1;
  localparam logic [3:0] S_CSTART = 4'd2;
  localparam logic [3:0] S_CDIV   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_DLT    = 4'd6;
  localparam logic [3:0] S_MSTART = 4'd7;
  localparam logic [3:0] S_MDIV   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (sts_i.group_last) begin
            state_d = sts_i.calibrated ? S_MUL : S_CAL;
          end
        end
      end
      S_CAL: begin
        cmd_o.cal_add = 1'b1;
        state_d = sts_i.cal_last ? S_CSTART : S_IDLE;
      end
      S_CSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_CDIV;
      end
      S_CDIV: begin
        if (sts_i.div_done) begin
          cmd_o.base_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d = S_DLT;
      end
      S_DLT: begin
        cmd_o.dlt = 1'b1;
        state_d = S_MSTART;
      end
      S_MSTART: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_map = 1'b1;
        state_d = S_MDIV;
      end
      S_MDIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/sensor_baseline_ema_level_meter.sv -----
// Top level of the baseline-calibrated exponential filter level meter.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    sample_i
//   out       output     out_valid_o / out_ready_i  lit_count_o, rail_hit_o,
//                                                   level_delta_o, average_level_o
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A sample that does not close a group of 16 leaves the FSM ready in S_IDLE.
// A group closing during calibration adds the S_CAL state; the last one also
// S_CSTART and S_CDIV, where the 30-step shared divider forms the baseline.
// A group that closes after calibration passes through multiply, update,
// delta, then 30 divider steps for the bar mapping, plus the output load.
// The output register holds a result while out_ready_i is low; the next item is
// still taken, and a new result waits only if the previous one is unread.
// Reset needs no clearing pass; the configuration port is always ready.
`timescale 1ns / 1ps
module sensor_baseline_ema_level_meter (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [sbelm_pkg::SAMPLE_BITS-1:0]        sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [sbelm_pkg::STRIP_BITS-1:0]         lit_count_o,
  output logic                                     rail_hit_o,
  output logic signed [sbelm_pkg::DELTA_BITS-1:0]  level_delta_o,
  output logic [sbelm_pkg::SAMPLE_BITS-1:0]        average_level_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [sbelm_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [sbelm_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);
  import sbelm_pkg::*;

  `include "sensor_baseline_ema_level_meter_assert.svh"

  sbelm_cmd_t cmd;
  sbelm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sbelm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sbelm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .lit_count_o     (lit_count_o),
    .rail_hit_o      (rail_hit_o),
    .level_delta_o   (level_delta_o),
    .average_level_o (average_level_o)
  );

  `SBELM_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, cmd.div_start, !sts.div_busy,
                    "Divider started while busy.")
  `SBELM_ASSERT_IMP(a_no_input_during_div, clk_i, rst_ni, in_ready_o, !sts.div_busy,
                    "Input ready while the divider is busy.")
  `SBELM_ASSERT_NXT(a_group_end_stalls, clk_i, rst_ni,
                    in_valid_i && in_ready_o && sts.group_last, !in_ready_o,
                    "Input taken right after a group closed.")

endmodule
